// ----- rtl/erg_pkg.sv -----
// Shared constants for the expert route grouping block.
// Field widths, function and result kind codes, parameter defaults.
// No dependencies.
package erg_pkg;

   localparam int DEF_NUM_EXPERTS = 64;
   localparam int DEF_MAX_ROWS    = 4096;

   localparam int ID_W    = 7;
   localparam int POS_W   = 12;
   localparam int EXP_W   = 6;
   localparam int SLOT_W  = 12;
   localparam int COUNT_W = 13;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;

   localparam logic FUNC_ROUTE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   localparam logic KIND_ROUTE = 1'b0;
   localparam logic KIND_COUNT = 1'b1;

endpackage

// ----- rtl/erg_count_ram.sv -----
// Per-expert count memory: one write port, one registered read port.
// Uses erg_pkg only for conventions; depth and widths come from parameters.
module erg_count_ram
   import erg_pkg::*;
#(
   parameter int DEPTH  = DEF_NUM_EXPERTS,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 13
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/erg_clear_seq.sv -----
// Post-reset clearing sweep over the count memory, one entry per cycle.
// Depends on erg_pkg for parameter defaults.
module erg_clear_seq
   import erg_pkg::*;
#(
   parameter int DEPTH  = DEF_NUM_EXPERTS,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              reset,
   output logic              active,
   output logic [ADDR_W-1:0] addr
);

   localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

   logic              active_ff, active_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;

   always_comb begin
      active_in = active_ff;
      addr_in   = addr_ff;
      if (active_ff) begin
         if (addr_ff == LAST) begin
            active_in = 1'b0;
         end else begin
            addr_in = addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b1;
         addr_ff   <= '0;
      end else begin
         active_ff <= active_in;
         addr_ff   <= addr_in;
      end
   end

   assign active = active_ff;
   assign addr   = addr_ff;

endmodule

// ----- rtl/expert_route_grouping.sv -----
// Path: an accepted req transfer is registered into stage 1 with its count read, then its result into the rsp register.
// Throughput: one item per cycle; the counter read-modify-write in stage 1,
// with forwarding from the previous write, sets that rate. A stalled result
// holds stage 1 and drops req_tready.
// Reset: synchronous; a clearing pass over every count entry follows, with
// req_tready low, before the first item is taken.
module expert_route_grouping
   import erg_pkg::*;
#(
   parameter int NUM_EXPERTS = DEF_NUM_EXPERTS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // expert_id[6:0], position[18:7], zero pad
   input  logic                  req_tuser,  // func
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // expert[5:0], slot[17:6],
                                             // entry_position[29:18], count[42:30], zero pad
   output logic                  rsp_tuser   // kind
);

   localparam int IDX_W = (NUM_EXPERTS > 1) ? $clog2(NUM_EXPERTS) : 1;
   localparam int CNT_W = $clog2(MAX_ROWS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ROWS);

   logic             clear_active;
   logic [IDX_W-1:0] clear_addr;

   logic [ID_W-1:0]  req_id;
   logic [31:0]      req_id_ext;
   logic             req_in_range;
   logic [IDX_W-1:0] req_idx;
   logic             accept;

   logic             s1_valid_ff, s1_valid_in;
   logic             s1_func_ff;
   logic             s1_in_range_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic [POS_W-1:0] s1_pos_ff;

   logic             fwd_valid_ff, fwd_valid_in;
   logic [IDX_W-1:0] fwd_idx_ff, fwd_idx_in;
   logic [CNT_W-1:0] fwd_cnt_ff, fwd_cnt_in;

   logic [CNT_W-1:0] ram_rd_data;
   logic [CNT_W-1:0] cnt;
   logic [31:0]      cnt_ext;
   logic             not_full;
   logic             s1_emit;
   logic             s1_adv;
   logic             s1_fire;
   logic             s1_wr;
   logic [CNT_W-1:0] s1_wr_data;

   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic [CNT_W-1:0] ram_wr_data;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  out_load;

   erg_clear_seq #(
      .DEPTH  (NUM_EXPERTS),
      .ADDR_W (IDX_W)
   ) u_clear (
      .clock  (clock),
      .reset  (reset),
      .active (clear_active),
      .addr   (clear_addr)
   );

   erg_count_ram #(
      .DEPTH  (NUM_EXPERTS),
      .ADDR_W (IDX_W),
      .DATA_W (CNT_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (req_idx),
      .rd_data (ram_rd_data)
   );

   // decode the incoming transfer
   assign req_id       = req_tdata[ID_W-1:0];
   assign req_id_ext   = 32'(req_id[ID_W-2:0]);
   assign req_in_range = !req_id[ID_W-1] && (req_id_ext < 32'(NUM_EXPERTS));
   assign req_idx      = req_id_ext[IDX_W-1:0];

   // stage 1: counter update with forwarding
   assign cnt      = (fwd_valid_ff && (fwd_idx_ff == s1_idx_ff)) ? fwd_cnt_ff : ram_rd_data;
   assign cnt_ext  = 32'(cnt);
   assign not_full = cnt < CNT_MAX;
   assign s1_emit  = s1_valid_ff && s1_in_range_ff && ((s1_func_ff == FUNC_READ) || not_full);
   assign s1_adv   = !s1_emit || !rsp_valid_ff || rsp_tready;
   assign s1_fire  = s1_valid_ff && s1_adv;
   assign s1_wr    = s1_fire && s1_emit;
   assign s1_wr_data = (s1_func_ff == FUNC_READ) ? '0 : cnt + 1'b1;

   assign req_tready = !clear_active && s1_adv;
   assign accept     = req_tvalid && req_tready;

   assign ram_wr_en   = clear_active || s1_wr;
   assign ram_wr_addr = clear_active ? clear_addr : s1_idx_ff;
   assign ram_wr_data = clear_active ? '0 : s1_wr_data;

   assign out_load = s1_wr;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end

      fwd_valid_in = fwd_valid_ff;
      fwd_idx_in   = fwd_idx_ff;
      fwd_cnt_in   = fwd_cnt_ff;
      if (s1_fire) begin
         fwd_valid_in = s1_wr;
         fwd_idx_in   = s1_idx_ff;
         fwd_cnt_in   = s1_wr_data;
      end

      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);

      rsp_data_in = '0;
      rsp_data_in[EXP_W-1:0] = EXP_W'(s1_idx_ff);
      if (s1_func_ff == FUNC_READ) begin
         rsp_kind_in = KIND_COUNT;
         rsp_data_in[EXP_W+SLOT_W+POS_W +: COUNT_W] = cnt_ext[COUNT_W-1:0];
      end else begin
         rsp_kind_in = KIND_ROUTE;
         rsp_data_in[EXP_W +: SLOT_W]       = cnt_ext[SLOT_W-1:0];
         rsp_data_in[EXP_W+SLOT_W +: POS_W] = s1_pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_idx_ff <= fwd_idx_in;
      fwd_cnt_ff <= fwd_cnt_in;
      if (accept) begin
         s1_func_ff     <= req_tuser;
         s1_in_range_ff <= req_in_range;
         s1_idx_ff      <= req_idx;
         s1_pos_ff      <= req_tdata[ID_W +: POS_W];
      end
      if (out_load) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

`ifndef NO_ASSERTIONS
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_active |-> !req_tready)
      else $error("transfer accepted during clearing pass");

   a_no_update_in_clear: assert property (@(posedge clock) disable iff (reset)
      !(clear_active && s1_wr))
      else $error("counter update collides with clearing pass");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten while stalled");

   a_clear_leaves_empty: assert property (@(posedge clock) disable iff (reset)
      $fell(clear_active) |-> !s1_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty at end of clearing pass");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for expert_route_grouping: streams route and read transfers,
// predicts each expert's placements and counts, and checks every result transfer in order.
// Depends on erg_pkg and the expert_route_grouping RTL.
`timescale 1ns / 100ps

module testbench
   import erg_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int RANDOM_ITEMS   = 1430;

   typedef struct {
      logic              func;
      logic [ID_W-1:0]   expert_id;
      logic [POS_W-1:0]  position;
   } route_req_type;

   typedef struct {
      logic               kind;
      logic [EXP_W-1:0]   expert;
      logic [SLOT_W-1:0]  slot;
      logic [POS_W-1:0]   entry_position;
      logic [COUNT_W-1:0] count;
   } grouping_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // expert_id[6:0], position[18:7], zero pad
   logic                  req_tuser = 1'b0;  // func
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // expert[5:0], slot[17:6], entry_position[29:18],
                                      // count[42:30], zero pad
   logic                  rsp_tuser;  // kind

   route_req_type        pending_routes[$];
   grouping_result_type  expected_placements[$];
   logic [COUNT_W-1:0]   expert_tally [DEF_NUM_EXPERTS];

   logic req_fired = 1'b0;
   int   idle_cycles = 0;
   int   error_count = 0;
   int   n_placements = 0;
   int   n_reads = 0;
   int   n_ignored = 0;
   int   n_full_drops = 0;

   expert_route_grouping u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   task automatic queue_route(input logic func, input logic [ID_W-1:0] id,
                              input logic [POS_W-1:0] pos);
      route_req_type it;
      it.func = func;
      it.expert_id = id;
      it.position = pos;
      pending_routes.push_back(it);
   endtask

   task automatic group_entry(input route_req_type it);
      int e;
      grouping_result_type res;
      e = $signed(it.expert_id);
      if (e < 0 || e >= DEF_NUM_EXPERTS) begin
         n_ignored++;
         return;
      end
      res.expert = e[EXP_W-1:0];
      if (it.func == FUNC_READ) begin
         res.kind = KIND_COUNT;
         res.slot = '0;
         res.entry_position = '0;
         res.count = expert_tally[e];
         expert_tally[e] = '0;
         n_reads++;
      end else begin
         if (expert_tally[e] >= DEF_MAX_ROWS) begin
            n_full_drops++;
            return;
         end
         res.kind = KIND_ROUTE;
         res.slot = expert_tally[e][SLOT_W-1:0];
         res.entry_position = it.position;
         res.count = '0;
         expert_tally[e] = expert_tally[e] + 1'b1;
         n_placements++;
      end
      expected_placements.push_back(res);
   endtask

   task automatic check_field(input string name, input logic [RSP_DATA_W-1:0] want,
                              input logic [RSP_DATA_W-1:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // accept side: predict on request transfers, check result transfers
   always @(posedge clock) begin
      grouping_result_type want;
      if (reset) begin
         req_fired <= 1'b0;
         idle_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_placements.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, actual kind %0b data %0h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = expected_placements.pop_front();
               check_field("kind", want.kind, rsp_tuser);
               check_field("expert", want.expert, rsp_tdata[5:0]);
               check_field("slot", want.slot, rsp_tdata[17:6]);
               check_field("entry_position", want.entry_position, rsp_tdata[29:18]);
               check_field("count", want.count, rsp_tdata[42:30]);
               check_field("pad", '0, rsp_tdata[RSP_DATA_W-1:43]);
            end
         end
         if (req_tvalid && req_tready)
            group_entry(pending_routes.pop_front());
         req_fired <= req_tvalid && req_tready;
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // drive side: bursty sender, patterned receiver stalls
   int burst_left = 1;
   int gap_left = 0;
   int rsp_phase = 0;
   int rsp_mode = 0;
   logic [7:0] rsp_mask = 8'hff;

   always @(negedge clock) begin
      logic ready_next;
      route_req_type it;
      if (!reset) begin
         if (!(req_tvalid && !req_fired)) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_routes.size() > 0) begin
               it = pending_routes[0];
               req_tvalid <= 1'b1;
               req_tuser <= it.func;
               req_tdata <= {{(REQ_DATA_W-ID_W-POS_W){1'b0}}, it.position, it.expert_id};
               if (burst_left <= 1) begin
                  burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 32);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 :
                             ($urandom_range(0, 9) == 0) ? 20 : $urandom_range(1, 5);
               end else begin
                  burst_left = burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         if (rsp_phase == 0) begin
            rsp_mode = $urandom_range(0, 3);
            rsp_mask = 8'($urandom());
            rsp_phase = 48;
         end
         rsp_phase = rsp_phase - 1;
         case (rsp_mode)
            0: ready_next = 1'b1;
            1: ready_next = 1'($urandom_range(0, 1));
            2: ready_next = rsp_mask[3'(rsp_phase % 8)];
            default: ready_next = ($urandom_range(0, 4) == 0);
         endcase
         rsp_tready <= ready_next;
      end
   end

   initial begin
      int in_range;
      int pos_run;
      int r;
      int cycles;
      logic func;
      logic [ID_W-1:0] id;
      logic [POS_W-1:0] pos;
      bit timed_out;

      timed_out = 1'b0;
      cycles = 0;
      for (int i = 0; i < DEF_NUM_EXPERTS; i++)
         expert_tally[i] = '0;

      // directed: extremes, padding ids, read-and-clear, unused position on reads
      queue_route(FUNC_ROUTE, 7'd0, 12'd0);
      queue_route(FUNC_ROUTE, 7'd0, 12'd1);
      queue_route(FUNC_ROUTE, 7'd63, 12'd2);
      queue_route(FUNC_ROUTE, 7'h7f, 12'd3);
      queue_route(FUNC_ROUTE, 7'h40, 12'd4);
      queue_route(FUNC_READ, 7'd0, 12'hfff);
      queue_route(FUNC_READ, 7'd0, 12'd0);
      queue_route(FUNC_READ, 7'h7f, 12'd5);
      queue_route(FUNC_READ, 7'h40, 12'd6);
      queue_route(FUNC_ROUTE, 7'd63, 12'hfff);
      queue_route(FUNC_ROUTE, 7'd21, 12'haaa);
      queue_route(FUNC_ROUTE, 7'd42, 12'h555);
      queue_route(FUNC_ROUTE, 7'd42, 12'h100);
      queue_route(FUNC_ROUTE, 7'd42, 12'h0ff);
      queue_route(FUNC_READ, 7'd21, 12'h555);
      queue_route(FUNC_READ, 7'd42, 12'haaa);
      queue_route(FUNC_READ, 7'd63, 12'd0);
      queue_route(FUNC_READ, 7'd63, 12'd0);
      queue_route(FUNC_ROUTE, 7'd1, 12'd7);

      // random: mostly ascending routing lists, with padding ids and out-of-order noise
      in_range = 0;
      pos_run = 0;
      while (in_range < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 8)
            id = 7'($urandom_range(64, 127));
         else if (r < 50)
            id = 7'($urandom_range(0, 3));
         else
            id = 7'($urandom_range(0, 63));
         func = ($urandom_range(0, 99) < 12) ? FUNC_READ : FUNC_ROUTE;
         if ($urandom_range(0, 99) < 5) begin
            pos = 12'($urandom_range(0, 4095));
         end else begin
            pos_run = pos_run + $urandom_range(0, 2);
            if (pos_run > 4095)
               pos_run = 0;
            pos = 12'(pos_run);
         end
         queue_route(func, id, pos);
         if (!id[ID_W-1])
            in_range++;
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (!timed_out && (pending_routes.size() > 0 || expected_placements.size() > 0)) begin
         @(negedge clock);
         cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT || cycles >= CYCLE_LIMIT)
            timed_out = 1'b1;
      end
      if (!timed_out)
         repeat (8) @(negedge clock);

      $display("Run covered %0d placements, %0d count reads and %0d ignored ids,",
               n_placements, n_reads, n_ignored);
      $display("plus %0d routes dropped on a full expert list.", n_full_drops);
      if (!timed_out && error_count == 0 && expected_placements.size() == 0) begin
         $display("PASS expert_route_grouping");
      end else begin
         $display("FAIL expert_route_grouping");
      end
      $finish;
   end

endmodule
